FILE: design/rpab_pkg.sv
// ----------------------------------------------------------------------------
// rpab_pkg
// Shared types and constants for the constant-alpha RGBA pixel blender.
// ----------------------------------------------------------------------------
package rpab_pkg;

  // channel layout: three color channels and alpha, one byte each
  localparam int unsigned NUM_CH = 4;
  localparam int unsigned CH_W   = 8;
  // src*gain + dst*factor, both products below 2^16
  localparam int unsigned SUM_W  = 2 * CH_W + 1;

  localparam logic [CH_W-1:0] ALPHA_MAX = 8'hFF;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_GLOBAL_ALPHA = 1'b0;
  localparam logic [CH_W-1:0] GLOBAL_ALPHA_RST = 8'hFF;

  typedef logic [CH_W-1:0] chan_t;

  // what the merge stage does with the lane results
  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_CLEAR,
    MODE_MASK,
    MODE_BLEND
  } mode_e;

  // one lane's registered result
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    chan_t            dst;
  } lane_res_t;

endpackage

FILE: design/rpab_if.sv
// ----------------------------------------------------------------------------
// rpab_if
// Valid/ready channels carrying a source/destination pixel pair and a result.
// ----------------------------------------------------------------------------
interface rpab_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_c0;
  logic [7:0] src_c1;
  logic [7:0] src_c2;
  logic [7:0] src_alpha;
  logic [7:0] dst_c0;
  logic [7:0] dst_c1;
  logic [7:0] dst_c2;
  logic [7:0] dst_alpha;

  modport source (
    output valid, src_c0, src_c1, src_c2, src_alpha,
           dst_c0, dst_c1, dst_c2, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_c0, src_c1, src_c2, src_alpha,
           dst_c0, dst_c1, dst_c2, dst_alpha,
    output ready
  );
endinterface

interface rpab_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_c0;
  logic [7:0] out_c1;
  logic [7:0] out_c2;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_c0, out_c1, out_c2, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_c0, out_c1, out_c2, out_alpha,
    output ready
  );
endinterface

FILE: design/rpab_lane.sv
// ----------------------------------------------------------------------------
// rpab_lane
// One channel lane: registered weighted sum src*gain + dst*factor.
// ----------------------------------------------------------------------------
module rpab_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  rpab_pkg::chan_t    src_i,
  input  rpab_pkg::chan_t    dst_i,
  input  rpab_pkg::chan_t    gain_i,
  input  rpab_pkg::chan_t    factor_i,
  output rpab_pkg::lane_res_t res_o
);
  import rpab_pkg::*;

  logic [2*CH_W-1:0] prod_src;
  logic [2*CH_W-1:0] prod_dst;
  logic [SUM_W-1:0]  sum_d;
  logic [SUM_W-1:0]  sum_q;
  chan_t             dst_q;

  // two byte products and their sum
  always_comb begin
    prod_src = src_i * gain_i;
    prod_dst = dst_i * factor_i;
    sum_d    = {1'b0, prod_src} + {1'b0, prod_dst};
  end

  // lane register, advances with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
      dst_q <= dst_i;
    end
  end

  assign res_o.sum = sum_q;
  assign res_o.dst = dst_q;

endmodule

FILE: design/rpab_merge.sv
// ----------------------------------------------------------------------------
// rpab_merge
// Combines the lane sums into the new pixel: scale, saturate and mode select.
// ----------------------------------------------------------------------------
module rpab_merge (
  input  rpab_pkg::lane_res_t res_i [rpab_pkg::NUM_CH],
  input  rpab_pkg::mode_e     mode_i,
  output rpab_pkg::chan_t     pix_o [rpab_pkg::NUM_CH]
);
  import rpab_pkg::*;

  logic [CH_W:0] scaled [NUM_CH];
  chan_t         sat    [NUM_CH];

  // drop the fraction and clamp at full scale
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      scaled[i] = res_i[i].sum[SUM_W-1:CH_W];
      sat[i]    = scaled[i][CH_W] ? ALPHA_MAX : scaled[i][CH_W-1:0];
    end
  end

  // per-pixel mode select
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      unique case (mode_i)
        MODE_PASS:  pix_o[i] = res_i[i].dst;
        MODE_CLEAR: pix_o[i] = '0;
        MODE_MASK:  pix_o[i] = sat[i];
        MODE_BLEND: pix_o[i] = sat[i];
        default:    pix_o[i] = res_i[i].dst;
      endcase
    end
  end

endmodule

FILE: design/rgba_pixel_alpha_blend.sv
// ----------------------------------------------------------------------------
// rgba_pixel_alpha_blend
// Constant-alpha blend of an RGBA8888 source pixel onto a destination pixel.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one source and one destination pixel per item, out_o the new
//   destination pixel. Both are valid/ready channels.
//   The APB port holds global_alpha at byte address 0 (reset 255):
//   0 leaves the destination as is, 255 scales the destination by the source
//   alpha (mask mode; a zero destination alpha passes), any other value mixes
//   both pixels with saturation. Write it only while no item is in flight.
// Timing:
//   three register stages (alpha complement, per-channel lanes, output
//   register), which each accepted item passes in that order.
//   One item per cycle is sustained while out_o.ready stays high; the four
//   channel lanes and the single complement multiplier are fully pipelined.
// Reset and stall:
//   reset empties the pipeline and restores global_alpha to 255.
//   When out_o.ready is low with a result waiting, the whole pipeline holds
//   and in_i.ready drops; up to three items sit in the block meanwhile.
// ----------------------------------------------------------------------------
module rgba_pixel_alpha_blend (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rpab_in_if.sink                      in_i,
  rpab_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpab_pkg::APB_AW-1:0]  paddr,
  input  logic [rpab_pkg::APB_DW-1:0]  pwdata,
  output logic [rpab_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import rpab_pkg::*;

  logic          en;
  logic          reg_wr;
  logic          reg_hit;
  chan_t         global_d, global_q;

  chan_t         in_src [NUM_CH];
  chan_t         in_dst [NUM_CH];
  logic [2*CH_W-1:0] comp_prod;
  mode_e         mode_d;
  chan_t         gain_d, factor_d;

  logic          s1_vld_q, s2_vld_q, out_vld_q;
  chan_t         s1_src_q [NUM_CH];
  chan_t         s1_dst_q [NUM_CH];
  chan_t         s1_gain_q, s1_factor_q;
  mode_e         s1_mode_q, s2_mode_q;

  lane_res_t     lane_res [NUM_CH];
  chan_t         merge_pix [NUM_CH];
  chan_t         out_pix_q [NUM_CH];

  // configuration register
  assign reg_hit = (paddr[2] == REG_GLOBAL_ALPHA);
  assign reg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(APB_DW-CH_W){1'b0}}, global_q} : '0;
  assign global_d = reg_wr ? pwdata[CH_W-1:0] : global_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_q <= GLOBAL_ALPHA_RST;
    end else begin
      global_q <= global_d;
    end
  end

  // pipeline advances unless a result is stuck at the output
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  assign in_src[0] = in_i.src_c0;
  assign in_src[1] = in_i.src_c1;
  assign in_src[2] = in_i.src_c2;
  assign in_src[3] = in_i.src_alpha;
  assign in_dst[0] = in_i.dst_c0;
  assign in_dst[1] = in_i.dst_c1;
  assign in_dst[2] = in_i.dst_c2;
  assign in_dst[3] = in_i.dst_alpha;

  // mode decode and lane weights
  always_comb begin
    comp_prod = (ALPHA_MAX - in_i.src_alpha) * global_q;
    priority if (global_q == '0) begin
      mode_d = MODE_PASS;
    end else if (global_q == ALPHA_MAX && in_i.dst_alpha == '0) begin
      mode_d = MODE_PASS;
    end else if (global_q == ALPHA_MAX && in_i.src_alpha == '0) begin
      mode_d = MODE_CLEAR;
    end else if (global_q == ALPHA_MAX) begin
      mode_d = MODE_MASK;
    end else begin
      mode_d = MODE_BLEND;
    end
    if (mode_d == MODE_MASK) begin
      gain_d   = '0;
      factor_d = in_i.src_alpha;
    end else begin
      gain_d   = global_q;
      factor_d = comp_prod[2*CH_W-1:CH_W];
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_i.valid;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  // stage 1 payload, stage 2 mode and output pixel register
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_src_q    <= in_src;
      s1_dst_q    <= in_dst;
      s1_gain_q   <= gain_d;
      s1_factor_q <= factor_d;
      s1_mode_q   <= mode_d;
      s2_mode_q   <= s1_mode_q;
      out_pix_q   <= merge_pix;
    end
  end

  // channel lanes
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    rpab_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .src_i    (s1_src_q[g]),
      .dst_i    (s1_dst_q[g]),
      .gain_i   (s1_gain_q),
      .factor_i (s1_factor_q),
      .res_o    (lane_res[g])
    );
  end

  // merge lanes into the new pixel
  rpab_merge u_merge (
    .res_i  (lane_res),
    .mode_i (s2_mode_q),
    .pix_o  (merge_pix)
  );

  assign out_o.valid     = out_vld_q;
  assign out_o.out_c0    = out_pix_q[0];
  assign out_o.out_c1    = out_pix_q[1];
  assign out_o.out_c2    = out_pix_q[2];
  assign out_o.out_alpha = out_pix_q[3];

  // cleared pixel leaves the merge stage as all zeros
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && en && s2_mode_q == MODE_CLEAR) |=>
      (out_o.out_c0 == '0 && out_o.out_c1 == '0 &&
       out_o.out_c2 == '0 && out_o.out_alpha == '0))
    else $error("cleared pixel not zero");

  // pass mode returns the destination's channel 0 and alpha
  a_pass_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && en && s2_mode_q == MODE_PASS) |=>
      (out_o.out_c0 == $past(lane_res[0].dst) &&
       out_o.out_alpha == $past(lane_res[3].dst)))
    else $error("pass mode altered destination");

  // register write takes the low byte
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reg_wr |=> (global_q == $past(pwdata[CH_W-1:0])))
    else $error("global alpha write lost");

  // stall holds the valid chain with the output result still waiting
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s1_vld_q) && $stable(s2_vld_q) && out_vld_q))
    else $error("pipeline moved during stall");

endmodule
